>>> hdl/firmware_config_item_port_assert.svh
// assertion macros used by the port checker
`ifndef FIRMWARE_CONFIG_ITEM_PORT_ASSERT_SVH
`define FIRMWARE_CONFIG_ITEM_PORT_ASSERT_SVH

// condition now implies consequence in the same cycle
`define FCIP_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("firmware config port: same-cycle check failed");

// condition now implies consequence in the next cycle
`define FCIP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("firmware config port: next-cycle check failed");

`endif

>>> hdl/fcip_pkg.sv
// ---------------------------------------------------------------------------
// fcip_pkg
// shared constants and types of the firmware configuration item port
// ---------------------------------------------------------------------------
package fcip_pkg;

  localparam int MAX_ITEMS     = 64;
  localparam int SLOT_BYTES    = 256;
  localparam int TABLE_ENTRIES = 2 * MAX_ITEMS;
  localparam int IDX_W         = $clog2(MAX_ITEMS);
  localparam int SLOT_W        = IDX_W + 1;
  localparam int OFF_W         = $clog2(SLOT_BYTES);
  localparam int LEN_W         = 9;
  localparam int META_W        = LEN_W + 1;
  localparam int BYTE_DEPTH    = TABLE_ENTRIES * SLOT_BYTES;
  localparam int BYTE_AW       = SLOT_W + OFF_W;

  localparam logic [15:0] KEY_INVALID = 16'hFFFF;
  localparam int KEY_BANK_BIT  = 15;
  localparam int KEY_WRITE_BIT = 14;

  typedef enum logic [2:0] {
    CMD_SELECT    = 3'd0,
    CMD_READ      = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_SET_ENTRY = 3'd3,
    CMD_LOAD_BYTE = 3'd4
  } fcip_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } fcip_state_t;

endpackage

>>> hdl/fcip_ram.sv
// ---------------------------------------------------------------------------
// fcip_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module fcip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/firmware_config_item_port.sv
// ---------------------------------------------------------------------------
// firmware_config_item_port
// selector/data firmware configuration device with host load commands
// ---------------------------------------------------------------------------
// usage
//   input channel (in_*): one command word per handshake: select key, data
//   read, data write, host set entry, host load byte. a word is taken when
//   in_valid is high and in_stall low.
//   result channel (out_*): exactly one result word per command, in order,
//   taken when out_valid is high and out_stall low.
// timing
//   each command passes ST_IDLE and ST_EXEC: the accept edge issues the table
//   and byte memory reads, the next edge does the modify/write-back and loads
//   the result register. out_valid rises at the edge after acceptance.
//   no new command is taken while one is in ST_EXEC, as the memories register
//   their reads ahead of the read-modify-write step.
// reset
//   rst_n clears the key, offset and the valid flags of the length/writable
//   table: every entry reads as length zero, not writable. the byte store
//   is not cleared; the host must load it before reads (not enforced).
// stall
//   while out_stall holds, the result word stays put; a new command is taken
//   only if the result register will be free when that command completes.
// ---------------------------------------------------------------------------
module firmware_config_item_port (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_key,
  input  logic [7:0]  in_data_byte,
  input  logic [8:0]  in_host_length,
  input  logic [7:0]  in_host_offset,
  input  logic        in_host_writable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_status_ok,
  output logic        out_commit,
  output logic [15:0] out_commit_key
);

  import fcip_pkg::*;

  // item index in range for this key
  function automatic logic idx_ok(input logic [15:0] k);
    idx_ok = {1'b0, k[13:0]} < 15'(MAX_ITEMS);
  endfunction

  // table position: bank bit over item index
  function automatic logic [SLOT_W-1:0] key_slot(input logic [15:0] k);
    key_slot = {k[KEY_BANK_BIT], k[IDX_W-1:0]};
  endfunction

  // sequencer
  fcip_state_t state_r, state_nxt;
  logic        accept;
  logic        exec;

  // guest-visible selector state
  logic [15:0]      current_key_r, current_key_nxt;
  logic [LEN_W-1:0] current_offset_r, current_offset_nxt;

  // latched command word
  logic [2:0]       cmd_r;
  logic [15:0]      key_r;
  logic [7:0]       data_r;
  logic [LEN_W-1:0] hlen_r;
  logic [7:0]       hoff_r;
  logic             hwr_r;

  // length/writable table valid flags, cleared by reset
  logic [TABLE_ENTRIES-1:0] meta_vld_r;

  // memory ports
  logic              meta_wr_en;
  logic [SLOT_W-1:0] meta_wr_addr;
  logic [META_W-1:0] meta_wr_data;
  logic [META_W-1:0] meta_rd_data;
  logic               byte_wr_en;
  logic [BYTE_AW-1:0] byte_wr_addr;
  logic [7:0]         byte_rd_data;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  rdata_r, rdata_nxt;
  logic        ok_r, ok_nxt;
  logic        commit_r, commit_nxt;
  logic [15:0] ckey_r, ckey_nxt;

  // decode of the table entry under the current key
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] host_slot;
  logic              cur_ok;
  logic [LEN_W-1:0]  cur_len;
  logic              cur_wr;
  logic [LEN_W-1:0]  off_inc;
  logic [LEN_W-1:0]  len_sat;

  assign cur_slot  = key_slot(current_key_r);
  assign host_slot = key_slot(key_r);
  assign cur_ok    = (current_key_r != KEY_INVALID) && idx_ok(current_key_r);
  assign cur_len   = meta_vld_r[cur_slot] ? meta_rd_data[LEN_W-1:0] : '0;
  assign cur_wr    = meta_vld_r[cur_slot] & meta_rd_data[LEN_W];
  assign off_inc   = LEN_W'(current_offset_r + 1'b1);
  assign len_sat   = (hlen_r > LEN_W'(SLOT_BYTES)) ? LEN_W'(SLOT_BYTES) : hlen_r;

  // length and writable mark, one word per entry
  fcip_ram #(
    .WIDTH (META_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_wr_en),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr_data),
    .rd_en   (accept),
    .rd_addr (cur_slot),
    .rd_data (meta_rd_data)
  );

  // entry byte slots
  fcip_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_DEPTH)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (byte_wr_en),
    .wr_addr (byte_wr_addr),
    .wr_data (data_r),
    .rd_en   (accept),
    .rd_addr ({cur_slot, current_offset_r[OFF_W-1:0]}),
    .rd_data (byte_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      current_key_r    <= '0;
      current_offset_r <= '0;
      meta_vld_r       <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      current_key_r    <= current_key_nxt;
      current_offset_r <= current_offset_nxt;
      out_valid_r      <= out_valid_nxt;
      if (meta_wr_en) begin
        meta_vld_r[meta_wr_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      key_r  <= in_key;
      data_r <= in_data_byte;
      hlen_r <= in_host_length;
      hoff_r <= in_host_offset;
      hwr_r  <= in_host_writable;
    end
    if (exec) begin
      rdata_r  <= rdata_nxt;
      ok_r     <= ok_nxt;
      commit_r <= commit_nxt;
      ckey_r   <= ckey_nxt;
    end
  end

  always_comb begin
    state_nxt          = state_r;
    accept             = 1'b0;
    exec               = 1'b0;
    in_stall           = 1'b1;
    current_key_nxt    = current_key_r;
    current_offset_nxt = current_offset_r;
    meta_wr_en         = 1'b0;
    meta_wr_addr       = host_slot;
    meta_wr_data       = {hwr_r, len_sat};
    byte_wr_en         = 1'b0;
    byte_wr_addr       = {cur_slot, current_offset_r[OFF_W-1:0]};
    rdata_nxt          = '0;
    ok_nxt             = 1'b1;
    commit_nxt         = 1'b0;
    ckey_nxt           = '0;
    out_valid_nxt      = out_valid_r & out_stall;

    case (state_r)
      ST_IDLE: begin
        // result register must be free by the time this word completes
        in_stall = out_valid_r & out_stall;
        if (in_valid && !in_stall) begin
          accept    = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        exec          = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        case (cmd_r)
          CMD_SELECT: begin
            current_offset_nxt = '0;
            if (idx_ok(key_r)) begin
              current_key_nxt = key_r;
            end else begin
              current_key_nxt = KEY_INVALID;
              ok_nxt          = 1'b0;
            end
          end
          CMD_READ: begin
            if (cur_ok && (current_offset_r < cur_len)) begin
              rdata_nxt          = byte_rd_data;
              current_offset_nxt = off_inc;
            end
          end
          CMD_WRITE: begin
            // length never exceeds the slot, so the length check bounds the slot too
            if (cur_ok && current_key_r[KEY_WRITE_BIT] && cur_wr &&
                (current_offset_r < cur_len)) begin
              byte_wr_en = 1'b1;
              if (off_inc == cur_len) begin
                commit_nxt         = 1'b1;
                ckey_nxt           = current_key_r;
                current_offset_nxt = '0;
              end else begin
                current_offset_nxt = off_inc;
              end
            end
          end
          CMD_SET_ENTRY: begin
            if (!idx_ok(key_r) || (hwr_r && !key_r[KEY_WRITE_BIT])) begin
              ok_nxt = 1'b0;
            end else begin
              meta_wr_en = 1'b1;
            end
          end
          CMD_LOAD_BYTE: begin
            byte_wr_addr = {host_slot, hoff_r[OFF_W-1:0]};
            if (!idx_ok(key_r) || ({1'b0, hoff_r} >= LEN_W'(SLOT_BYTES))) begin
              ok_nxt = 1'b0;
            end else begin
              byte_wr_en = 1'b1;
            end
          end
          default: begin
            // unused codes: no state change, status ok
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = rdata_r;
  assign out_status_ok  = ok_r;
  assign out_commit     = commit_r;
  assign out_commit_key = ckey_r;

endmodule

>>> hdl/fcip_checker.sv
// ---------------------------------------------------------------------------
// fcip_checker
// port-level checks of the firmware configuration item port
// ---------------------------------------------------------------------------
`include "firmware_config_item_port_assert.svh"

module fcip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_read_data,
  input logic        out_status_ok,
  input logic        out_commit,
  input logic [15:0] out_commit_key
);

  // stalled result word holds
  `FCIP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_data) && $stable(out_commit) && $stable(out_commit_key))

  // a word is being worked on in the cycle after acceptance
  `FCIP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // commit only for a key selected on the write channel, and never with a failure
  `FCIP_ASSERT_NOW(a_commit_key, out_valid && out_commit, out_commit_key[14] && out_status_ok && (out_read_data == 8'd0))

  // commit key is zero without a commit
  `FCIP_ASSERT_NOW(a_no_commit_key, out_valid && !out_commit, out_commit_key == 16'd0)

endmodule

bind firmware_config_item_port fcip_checker u_fcip_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_data  (out_read_data),
  .out_status_ok  (out_status_ok),
  .out_commit     (out_commit),
  .out_commit_key (out_commit_key)
);

>>> dv/firmware_config_item_port_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// firmware_config_item_port_tb
// self-checking bench for the firmware configuration selector/data port
// ---------------------------------------------------------------------------
// a short run of directed words covers the empty table, host loads, guest
// read streams, guest write-and-commit, invalid keys and spare commands.
// random item sequences (host set, byte loads, select, read or write
// stream) plus noise words then run under four handshake pressure phases.
// a local model of the key/offset and item table predicts every result
// word, and a checker compares each one field by field, in order.
// ---------------------------------------------------------------------------
module firmware_config_item_port_tb;
  import fcip_pkg::*;

  // spare command codes, decoded by the block as no-ops
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 16;    // settle time after the last result
  localparam int PHASE_WORDS  = 190;   // random words per pressure phase

  // one command word and one result word, as seen on the ports
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] key;
    logic [7:0]  data_byte;
    logic [8:0]  host_length;
    logic [7:0]  host_offset;
    logic        host_writable;
  } port_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        status_ok;
    logic        commit;
    logic [15:0] commit_key;
  } port_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_command;
  logic [15:0] in_key;
  logic [7:0]  in_data_byte;
  logic [8:0]  in_host_length;
  logic [7:0]  in_host_offset;
  logic        in_host_writable;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_data;
  logic        out_status_ok;
  logic        out_commit;
  logic [15:0] out_commit_key;

  // pressure knobs, percent per cycle
  int idle_pct;
  int stall_pct;

  // bookkeeping
  int words_sent;
  int results_checked;
  int commits_seen;
  int mismatch_count;

  // expected result words, oldest first
  port_result_t pending_results[$];

  // local copy of the port state
  logic [15:0] sel_key;
  logic [8:0]  sel_offset;
  logic [8:0]  item_length[TABLE_ENTRIES];
  logic        item_writable[TABLE_ENTRIES];
  logic [7:0]  item_bytes[BYTE_DEPTH];
  bit          byte_loaded[BYTE_DEPTH];

  firmware_config_item_port u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_key           (in_key),
    .in_data_byte     (in_data_byte),
    .in_host_length   (in_host_length),
    .in_host_offset   (in_host_offset),
    .in_host_writable (in_host_writable),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_status_ok    (out_status_ok),
    .out_commit       (out_commit),
    .out_commit_key   (out_commit_key)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // table position of a key; 0 when its item index is out of range
  function automatic bit item_slot(input logic [15:0] key, output int slot);
    int idx;
    idx  = int'(key[KEY_BANK_BIT-2:0]);
    slot = 0;
    if (idx >= MAX_ITEMS) return 1'b0;
    slot = (key[KEY_BANK_BIT] ? MAX_ITEMS : 0) + idx;
    return 1'b1;
  endfunction

  // applies one accepted word to the local state and returns its result
  function automatic port_result_t predict_port_result(input port_word_t w);
    port_result_t r;
    int           slot;
    int           addr;
    bit           hit;
    r           = '0;
    r.status_ok = 1'b1;
    case (w.command)
      CMD_SELECT: begin
        sel_offset = '0;
        if (item_slot(w.key, slot)) begin
          sel_key = w.key;
        end else begin
          sel_key     = KEY_INVALID;
          r.status_ok = 1'b0;
        end
      end
      CMD_READ: begin
        hit = item_slot(sel_key, slot);
        if (sel_key != KEY_INVALID && hit && sel_offset < item_length[slot]) begin
          r.read_data = item_bytes[slot * SLOT_BYTES + int'(sel_offset)];
          sel_offset++;
        end
      end
      CMD_WRITE: begin
        hit = item_slot(sel_key, slot);
        if (sel_key != KEY_INVALID && sel_key[KEY_WRITE_BIT] && hit &&
            item_writable[slot] && sel_offset < item_length[slot] &&
            int'(sel_offset) < SLOT_BYTES) begin
          addr              = slot * SLOT_BYTES + int'(sel_offset);
          item_bytes[addr]  = w.data_byte;
          byte_loaded[addr] = 1'b1;
          sel_offset++;
          // a full entry commits and rewinds
          if (sel_offset == item_length[slot]) begin
            r.commit     = 1'b1;
            r.commit_key = sel_key;
            sel_offset   = '0;
          end
        end
      end
      CMD_SET_ENTRY: begin
        hit = item_slot(w.key, slot);
        if (!hit || (w.host_writable && !w.key[KEY_WRITE_BIT])) begin
          r.status_ok = 1'b0;
        end else begin
          item_length[slot]   = (int'(w.host_length) > SLOT_BYTES) ?
                                LEN_W'(SLOT_BYTES) : w.host_length;
          item_writable[slot] = w.host_writable;
        end
      end
      CMD_LOAD_BYTE: begin
        hit = item_slot(w.key, slot);
        if (!hit || int'(w.host_offset) >= SLOT_BYTES) begin
          r.status_ok = 1'b0;
        end else begin
          addr              = slot * SLOT_BYTES + int'(w.host_offset);
          item_bytes[addr]  = w.data_byte;
          byte_loaded[addr] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // true when the next data read would return a byte the host never loaded
  function automatic bit read_hits_unloaded();
    int slot;
    if (sel_key == KEY_INVALID || !item_slot(sel_key, slot)) return 1'b0;
    if (sel_offset >= item_length[slot]) return 1'b0;
    return !byte_loaded[slot * SLOT_BYTES + int'(sel_offset)];
  endfunction

  // ---------------------------------------------------------------------
  // sending
  // ---------------------------------------------------------------------

  function automatic port_word_t make_word(input logic [2:0] cmd, input logic [15:0] key,
                                           input logic [7:0] data, input logic [8:0] hlen,
                                           input logic [7:0] hoff, input logic hwr);
    port_word_t w;
    w.command       = cmd;
    w.key           = key;
    w.data_byte     = data;
    w.host_length   = hlen;
    w.host_offset   = hoff;
    w.host_writable = hwr;
    return w;
  endfunction

  // presents one word, waits for the handshake and records its expectation.
  // valid is only lowered when a gap is drawn, so back-to-back words keep
  // valid high across the boundary
  task automatic send_word(input port_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= w.command;
    in_key           <= w.key;
    in_data_byte     <= w.data_byte;
    in_host_length   <= w.host_length;
    in_host_offset   <= w.host_offset;
    in_host_writable <= w.host_writable;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(predict_port_result(w));
    words_sent++;
  endtask

  // command helpers; fields the command ignores carry random junk
  task automatic do_select(input logic [15:0] key);
    send_word(make_word(CMD_SELECT, key, 8'($urandom), 9'($urandom), 8'($urandom),
                        1'($urandom)));
  endtask

  task automatic do_set(input logic [15:0] key, input int len, input bit wr);
    send_word(make_word(CMD_SET_ENTRY, key, 8'($urandom), 9'(len), 8'($urandom), wr));
  endtask

  task automatic do_load(input logic [15:0] key, input int off, input logic [7:0] data);
    send_word(make_word(CMD_LOAD_BYTE, key, data, 9'($urandom), 8'(off), 1'($urandom)));
  endtask

  task automatic do_write(input logic [7:0] data);
    send_word(make_word(CMD_WRITE, 16'($urandom), data, 9'($urandom), 8'($urandom),
                        1'($urandom)));
  endtask

  // never reads a byte that was not loaded: such a byte is loaded first
  task automatic do_read();
    if (read_hits_unloaded()) do_load(sel_key, int'(sel_offset), 8'($urandom));
    send_word(make_word(CMD_READ, 16'($urandom), 8'($urandom), 9'($urandom),
                        8'($urandom), 1'($urandom)));
  endtask

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at result %0d: expected %0h, got %0h",
               field, results_checked, want, got);
  endtask

  always @(posedge clk) begin
    port_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, out_read_data);
        if (out_status_ok !== want.status_ok)
          report_mismatch("status_ok", want.status_ok, out_status_ok);
        if (out_commit !== want.commit)
          report_mismatch("commit", want.commit, out_commit);
        if (out_commit_key !== want.commit_key)
          report_mismatch("commit_key", want.commit_key, out_commit_key);
      end
      if (out_commit === 1'b1) commits_seen++;
      results_checked++;
    end
  end

  // watchdog: ends the run once no word has moved for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending_results.size());
    $display("firmware_config_item_port test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------

  // after reset every entry has length zero, so a read gives zero
  task automatic test_empty_table_read();
    do_read();
  endtask

  // host set entry and load byte, accepted and rejected
  task automatic test_host_table_loads();
    do_set(16'h4001, 2, 1'b1);        // writable through the write channel
    do_set(16'h0002, 3, 1'b1);        // writable without channel: refused
    do_set(16'hC03F, 511, 1'b0);      // last arch item, length saturates
    do_set(16'h0040, 5, 1'b0);        // index just past the table
    do_load(16'hC03F, 255, 8'hFF);    // last byte of the last slot
    do_load(16'h3FFF, 0, 8'h11);      // largest index: refused
    do_load(16'h4001, 0, 8'hA5);
    do_load(16'h0001, 1, 8'h00);      // same entry, write bit clear
  endtask

  // read stream through a loaded entry and one past the end
  task automatic test_guest_read_stream();
    do_select(16'h0001);
    repeat (3) do_read();
  endtask

  // refused write on the read channel, then a fill that commits
  task automatic test_guest_write_commit();
    do_write(8'h77);
    do_select(16'h4001);
    do_write(8'h5A);
    do_write(8'hC3);
  endtask

  // invalid key: read gives zero, write dropped; non-writable entry refuses
  task automatic test_invalid_key_access();
    do_select(KEY_INVALID);
    do_read();
    do_write(8'h99);
    do_select(16'hC03F);
    do_write(8'h3C);
  endtask

  task automatic test_spare_commands();
    for (int c = int'(CMD_SPARE_FIRST); c <= int'(CMD_SPARE_LAST); c++)
      send_word(make_word(3'(c), 16'($urandom), 8'($urandom), 9'($urandom),
                          8'($urandom), 1'($urandom)));
  endtask

  // ---------------------------------------------------------------------
  // random traffic
  // ---------------------------------------------------------------------

  // one host-load / select / stream sequence; about one in ten is broken
  // (writable without channel, missing loads or a flipped write bit)
  task automatic run_item_sequence();
    logic [15:0] key;
    int          pick;
    int          len;
    int          span;
    int          extra;
    bit          chan;
    bit          wr;
    bit          broken;
    pick   = $urandom_range(0, 99);
    broken = ($urandom_range(0, 9) == 0);
    chan   = 1'($urandom_range(0, 1));
    key    = '0;
    key[KEY_BANK_BIT]  = 1'($urandom_range(0, 1));
    key[KEY_WRITE_BIT] = chan;
    // a few items get reused often so earlier contents get read again
    key[IDX_W-1:0] = IDX_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) :
                            $urandom_range(0, MAX_ITEMS - 1));
    if (pick < 2)      len = $urandom_range(SLOT_BYTES, 511);
    else if (pick < 8) len = 0;
    else               len = $urandom_range(1, 8);
    // saturated entries only stream a short prefix, keeps the word count even
    span  = (len > 8) ? 8 : len;
    wr    = chan ? 1'($urandom_range(0, 1)) : 1'b0;
    extra = $urandom_range(0, 2);
    if (broken) wr = ~wr;
    do_set(key, len, wr);
    for (int i = 0; i < span; i++)
      if (!broken || $urandom_range(0, 3) != 0) do_load(key, i, 8'($urandom));
    if (broken) key[KEY_WRITE_BIT] = ~key[KEY_WRITE_BIT];
    do_select(key);
    if (wr && chan) begin
      for (int i = 0; i < span; i++) do_write(8'($urandom));
    end else if ($urandom_range(0, 3) == 0) begin
      do_write(8'($urandom));
    end
    for (int i = 0; i < span + extra; i++) do_read();
  endtask

  // a short burst of words with arbitrary fields
  task automatic run_noise_burst();
    logic [15:0] key;
    logic [2:0]  cmd;
    int          n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      cmd = 3'($urandom_range(0, 7));
      key = 16'($urandom);
      if ($urandom_range(0, 1) == 0) key[KEY_BANK_BIT-2:IDX_W] = '0;
      if ($urandom_range(0, 15) == 0) key = KEY_INVALID;
      if (cmd == CMD_READ)
        do_read();
      else
        send_word(make_word(cmd, key, 8'($urandom), 9'($urandom_range(0, 511)),
                            8'($urandom), 1'($urandom)));
    end
  endtask

  task automatic run_random_phase(input int idle, input int stall, input int target);
    int start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = words_sent;
    while (words_sent - start < target) begin
      if ($urandom_range(0, 99) < 80) run_item_sequence();
      else                            run_noise_burst();
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, PHASE_WORDS);     // full rate
    run_random_phase(50, 0, PHASE_WORDS);    // sender gaps
    run_random_phase(0, 50, PHASE_WORDS);    // receiver back-pressure
    run_random_phase(7, 7, PHASE_WORDS);     // light pressure on both
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    int directed_words;
    idle_pct        = 0;
    stall_pct       = 0;
    words_sent      = 0;
    results_checked = 0;
    commits_seen    = 0;
    mismatch_count  = 0;
    sel_key         = '0;
    sel_offset      = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      item_length[i]   = '0;
      item_writable[i] = 1'b0;
    end
    for (int i = 0; i < BYTE_DEPTH; i++) begin
      item_bytes[i]  = '0;
      byte_loaded[i] = 1'b0;
    end
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_command       <= CMD_SELECT;
    in_key           <= '0;
    in_data_byte     <= '0;
    in_host_length   <= '0;
    in_host_offset   <= '0;
    in_host_writable <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table_read();
    test_host_table_loads();
    test_guest_read_stream();
    test_guest_write_commit();
    test_invalid_key_access();
    test_spare_commands();
    directed_words = words_sent;
    test_random_traffic();

    // drain: wait for every result word, then let the pipe settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    idle_pct  = 0;
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d directed and %0d random command words over four pressure phases",
             directed_words, words_sent - directed_words);
    $display("checked %0d result words, %0d with commit, %0d mismatches",
             results_checked, commits_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("firmware_config_item_port test passed");
    end else begin
      $display("firmware_config_item_port test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/fcip_pkg.sv
hdl/fcip_ram.sv
hdl/firmware_config_item_port.sv
hdl/fcip_checker.sv
dv/firmware_config_item_port_tb.sv
